@@ design/plc_pkg.sv @@
// Shared types and constants for the piecewise-linear calibration block.
// No dependencies; every other design file refers to this package by scope.
`default_nettype none

package plc_pkg;

  localparam int unsigned X_W    = 16;            // setpoint and breakpoint width
  localparam int unsigned V_W    = 12;            // DAC code width
  localparam int unsigned SEG_W  = 2;             // segment index width
  localparam int unsigned PROD_W = X_W + V_W;     // offset times level step
  localparam int unsigned Q_W    = V_W;           // quotient never exceeds a level step
  localparam int unsigned NREG   = 8;             // configuration registers
  localparam int unsigned IDX_W  = 3;             // register index width
  localparam int unsigned ADDR_W = IDX_W + 2;     // byte address width
  localparam int unsigned DATA_W = 32;            // configuration data width

  // Register indexes: breakpoints first, then levels
  localparam logic [IDX_W-1:0] REG_X0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_V0 = 3'd4;

  typedef logic [X_W-1:0] point_t;
  typedef logic [V_W-1:0] level_t;

  // Values that ride alongside the division
  typedef struct packed {
    level_t           va;
    logic             neg;
    logic             zero;
    logic [SEG_W-1:0] seg;
    logic             hit;
  } plc_side_t;

  // One link of the divider chain
  typedef struct packed {
    logic              valid;
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] dsh;
    logic [Q_W-1:0]    quo;
    plc_side_t         side;
  } plc_cell_t;

endpackage

`default_nettype wire

@@ design/piecewise_linear_calibration.sv @@
// Piecewise-linear calibration: setpoint to DAC drive code, one request per cycle.
// Pipeline: a result strobes once its request has passed two front stages,
// twelve divider cells at one quotient bit each, and one output register.
// Throughput: one request every cycle; busy stays low and results cannot be stalled.
// Reset: synchronous active-low rst_n clears all valid flags and the configuration registers to 0.
// Depends on plc_pkg, plc_regs, plc_front and plc_div_cell.
`default_nettype none

module piecewise_linear_calibration #(
  parameter int unsigned NUM_POINTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [plc_pkg::X_W-1:0]       in_setpoint,
  output logic                               out_strobe,
  output logic      [plc_pkg::V_W-1:0]       out_drive_code,
  output logic      [plc_pkg::SEG_W-1:0]     out_segment,
  output logic                               out_in_table,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [plc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [plc_pkg::DATA_W-1:0]    pwdata,
  output logic      [plc_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  plc_pkg::point_t           x [4];
  plc_pkg::level_t           v [4];
  plc_pkg::plc_cell_t        link [plc_pkg::Q_W+1];
  plc_pkg::plc_cell_t        last;
  logic [plc_pkg::V_W:0]     sum;

  logic                      strobe_r;
  logic [plc_pkg::V_W-1:0]   code_r;
  logic [plc_pkg::SEG_W-1:0] seg_r;
  logic                      hit_r;

  assign busy = 1'b0;

  plc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .x_o     (x),
    .v_o     (v)
  );

  plc_front #(
    .NUM_POINTS (NUM_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_i     (start & ~busy),
    .setpoint_i (in_setpoint),
    .x_i        (x),
    .v_i        (v),
    .cell_o     (link[0])
  );

  for (genvar i = 0; i < plc_pkg::Q_W; i++) begin : g_cell
    plc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  assign last = link[plc_pkg::Q_W];

  // Quotient is truncated magnitude; apply the sign of the level step
  assign sum = last.side.neg ? ({1'b0, last.side.va} - {1'b0, last.quo})
                             : ({1'b0, last.side.va} + {1'b0, last.quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!last.side.hit) begin
      code_r <= '0;
      seg_r  <= '0;
    end else begin
      code_r <= last.side.zero ? last.side.va : sum[plc_pkg::V_W-1:0];
      seg_r  <= last.side.seg;
    end
    hit_r <= last.side.hit;
  end

  assign out_strobe     = strobe_r;
  assign out_drive_code = code_r;
  assign out_segment    = seg_r;
  assign out_in_table   = hit_r;

endmodule

`default_nettype wire

@@ design/plc_regs.sv @@
// Configuration register bank with an APB-style write and read port.
// Depends on plc_pkg for widths and register indexes.
`default_nettype none

module plc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [plc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [plc_pkg::DATA_W-1:0]    pwdata,
  output logic      [plc_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output plc_pkg::point_t                    x_o [4],
  output plc_pkg::level_t                    v_o [4]
);

  logic [plc_pkg::IDX_W-1:0] idx;
  logic                      wr_en;
  plc_pkg::point_t           x_r [4];
  plc_pkg::level_t           v_r [4];

  assign idx    = paddr[plc_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        x_r[i] <= '0;
        v_r[i] <= '0;
      end
    end else if (wr_en) begin
      if (idx < plc_pkg::REG_V0) begin
        x_r[idx[1:0]] <= pwdata[plc_pkg::X_W-1:0];
      end else begin
        v_r[idx[1:0]] <= pwdata[plc_pkg::V_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx < plc_pkg::REG_V0) begin
      prdata = {{(plc_pkg::DATA_W-plc_pkg::X_W){1'b0}}, x_r[idx[1:0]]};
    end else begin
      prdata = {{(plc_pkg::DATA_W-plc_pkg::V_W){1'b0}}, v_r[idx[1:0]]};
    end
  end

  assign x_o = x_r;
  assign v_o = v_r;

endmodule

`default_nettype wire

@@ design/plc_front.sv @@
// Front end: segment search, then the offset-times-step multiply.
// Depends on plc_pkg; feeds the first cell of the divider chain.
`default_nettype none

module plc_front #(
  parameter int unsigned NUM_POINTS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take_i,
  input  wire plc_pkg::point_t setpoint_i,
  input  wire plc_pkg::point_t x_i [4],
  input  wire plc_pkg::level_t v_i [4],
  output plc_pkg::plc_cell_t cell_o
);

  localparam int NSEG = int'(NUM_POINTS) - 1;

  logic                      hit;
  logic [plc_pkg::SEG_W-1:0] sel;
  plc_pkg::point_t           xa, xb;

  // stage A
  logic                      a_valid_r;
  plc_pkg::point_t           a_d_r, a_dx_r;
  plc_pkg::level_t           a_va_r, a_vb_r;
  logic [plc_pkg::SEG_W-1:0] a_seg_r;
  logic                      a_hit_r;

  // stage B
  logic                      neg;
  plc_pkg::level_t           mag;
  logic                      b_valid_r;
  plc_pkg::plc_cell_t        b_data_r;

  // Lowest enclosing segment wins: walk downwards and overwrite
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int k = NSEG - 1; k >= 0; k--) begin
      if (x_i[k] <= setpoint_i && setpoint_i <= x_i[k+1]) begin
        hit = 1'b1;
        sel = plc_pkg::SEG_W'(k);
      end
    end
    xa = x_i[sel];
    xb = x_i[sel + 2'd1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= take_i;
    end
  end

  always_ff @(posedge clk) begin
    a_d_r   <= setpoint_i - xa;
    a_dx_r  <= xb - xa;
    a_va_r  <= v_i[sel];
    a_vb_r  <= v_i[sel + 2'd1];
    a_seg_r <= sel;
    a_hit_r <= hit;
  end

  assign neg = a_vb_r < a_va_r;
  assign mag = neg ? (a_va_r - a_vb_r) : (a_vb_r - a_va_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_data_r.valid     <= 1'b0;
    b_data_r.rem       <= plc_pkg::PROD_W'(a_d_r) * plc_pkg::PROD_W'(mag);
    // Divisor aligned to the top quotient bit
    b_data_r.dsh       <= plc_pkg::PROD_W'({a_dx_r, {(plc_pkg::Q_W-1){1'b0}}});
    b_data_r.quo       <= '0;
    b_data_r.side.va   <= a_va_r;
    b_data_r.side.neg  <= neg;
    b_data_r.side.zero <= (a_dx_r == '0);
    b_data_r.side.seg  <= a_seg_r;
    b_data_r.side.hit  <= a_hit_r;
  end

  always_comb begin
    cell_o       = b_data_r;
    cell_o.valid = b_valid_r;
  end

endmodule

`default_nettype wire

@@ design/plc_div_cell.sv @@
// One restoring-division cell: settles one quotient bit and passes on.
// Depends on plc_pkg for the link type.
`default_nettype none

module plc_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plc_pkg::plc_cell_t cell_i,
  output plc_pkg::plc_cell_t      cell_o
);

  logic               fits;
  logic               valid_r;
  plc_pkg::plc_cell_t data_r;

  assign fits = cell_i.rem >= cell_i.dsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_i.valid;
    end
  end

  // Subtract where the shifted divisor fits, then halve it for the next cell
  always_ff @(posedge clk) begin
    data_r.valid <= 1'b0;
    data_r.rem   <= fits ? (cell_i.rem - cell_i.dsh) : cell_i.rem;
    data_r.dsh   <= cell_i.dsh >> 1;
    data_r.quo   <= {cell_i.quo[plc_pkg::Q_W-2:0], fits};
    data_r.side  <= cell_i.side;
  end

  always_comb begin
    cell_o       = data_r;
    cell_o.valid = valid_r;
  end

endmodule

`default_nettype wire
